@@ rtl/vhc_pkg.sv @@
// shared constants, register indexes and types for the vibrational heat capacity unit
package vhc_pkg;

    // configuration register indexes
    localparam logic [2:0] C_REG_HALVES = 3'd0;
    localparam logic [2:0] C_REG_MODES  = 3'd1;
    localparam logic [2:0] C_REG_THETA0 = 3'd2;
    localparam logic [2:0] C_REG_THETA1 = 3'd3;
    localparam logic [2:0] C_REG_THETA2 = 3'd4;
    localparam logic [2:0] C_REG_THETA3 = 3'd5;
    localparam logic [2:0] C_REG_THETA4 = 3'd6;

    localparam int C_MAX_MODES  = 5;
    localparam int C_THETA_REGS = 5;
    localparam int C_NUM_CELLS  = (C_MAX_MODES < C_THETA_REGS) ? C_MAX_MODES : C_THETA_REGS;

    localparam logic [2:0] C_HALVES_RST = 3'd5;

    // term pipeline geometry
    localparam int C_DIV1_BITS     = 36;
    localparam int C_DIV2_BITS     = 52;
    localparam int C_TAYLOR_TERMS  = 16;
    localparam int C_SQUARINGS     = 5;
    localparam int C_A_LEN         = 2 * C_TAYLOR_TERMS + C_SQUARINGS + 1;
    localparam int C_TERM_LAT      = C_DIV1_BITS + C_A_LEN + 1 + C_DIV2_BITS + 4;
    localparam int C_SRES_LEN      = C_TERM_LAT - C_DIV1_BITS - 8;

    localparam logic [35:0] C_XQ_ONE    = 36'd65536;
    localparam logic [35:0] C_XQ_CUTOFF = 36'd1310720;
    localparam logic [23:0] C_CP_MAX    = 24'hFF_FFFF;
    localparam logic [24:0] C_ONE_Q16   = 25'd65536;

    // reciprocals for exact division by small constants, ceil(2^35 / k)
    localparam logic [35:0] C_TAYLOR_RECIP [C_TAYLOR_TERMS] = '{
        36'(((64'd1 << 35) + 64'd0)  / 64'd1),
        36'(((64'd1 << 35) + 64'd1)  / 64'd2),
        36'(((64'd1 << 35) + 64'd2)  / 64'd3),
        36'(((64'd1 << 35) + 64'd3)  / 64'd4),
        36'(((64'd1 << 35) + 64'd4)  / 64'd5),
        36'(((64'd1 << 35) + 64'd5)  / 64'd6),
        36'(((64'd1 << 35) + 64'd6)  / 64'd7),
        36'(((64'd1 << 35) + 64'd7)  / 64'd8),
        36'(((64'd1 << 35) + 64'd8)  / 64'd9),
        36'(((64'd1 << 35) + 64'd9)  / 64'd10),
        36'(((64'd1 << 35) + 64'd10) / 64'd11),
        36'(((64'd1 << 35) + 64'd11) / 64'd12),
        36'(((64'd1 << 35) + 64'd12) / 64'd13),
        36'(((64'd1 << 35) + 64'd13) / 64'd14),
        36'(((64'd1 << 35) + 64'd14) / 64'd15),
        36'(((64'd1 << 35) + 64'd15) / 64'd16)
    };

    // series reciprocals for small x, exact for 32 bit dividends
    localparam logic [32:0] C_RECIP_12     = 33'(((64'd1 << 36) + 64'd11) / 64'd12);
    localparam logic [32:0] C_RECIP_240    = 33'(((64'd1 << 40) + 64'd239) / 64'd240);
    localparam logic [32:0] C_RECIP_6048   = 33'(((64'd1 << 45) + 64'd6047) / 64'd6048);
    localparam logic [32:0] C_RECIP_172800 = 33'(((64'd1 << 50) + 64'd172799) / 64'd172800);

    typedef struct packed {
        logic [20:0] xq;
        logic        big;
        logic        low_x;
    } t_stage_a;

    typedef struct packed {
        logic [31:0] e;
        logic        dzero;
        logic        big;
        logic        low_x;
    } t_stage_b;

endpackage

@@ rtl/vhc_div_cell.sv @@
// one restoring division step: one quotient bit per cell
module vhc_div_cell import vhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_rem,
    input  logic [51:0] i_dq,
    input  logic [31:0] i_dvs,
    output logic [31:0] o_rem,
    output logic [51:0] o_dq,
    output logic [31:0] o_dvs
);
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_diff;

    assign w_trial = {i_rem, i_dq[51]};
    assign w_ge    = (w_trial >= {1'b0, i_dvs});
    assign w_diff  = w_trial - {1'b0, i_dvs};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            o_dq  <= {i_dq[50:0], w_ge};
            o_dvs <= i_dvs;
        end
    end
endmodule

@@ rtl/vhc_taylor_cell.sv @@
// one term of the alternating series for exp(-y); the product is registered before the divide and add
module vhc_taylor_cell import vhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [3:0]  i_k,
    input  logic [31:0] i_t,
    input  logic [30:0] i_y,
    input  logic [32:0] i_sum,
    output logic [31:0] o_t,
    output logic [30:0] o_y,
    output logic [32:0] o_sum
);
    logic [62:0] w_prod;
    logic [66:0] w_quot;
    logic [30:0] r_p;
    logic [30:0] r_y;
    logic [32:0] r_sum;
    logic [30:0] w_q;

    assign w_prod = i_t * i_y;
    assign w_quot = r_p * C_TAYLOR_RECIP[i_k];
    assign w_q    = w_quot[65:35];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= w_prod[61:31];
            r_y   <= i_y;
            r_sum <= i_sum;
            o_t   <= {1'b0, w_q};
            o_y   <= r_y;
            // k odd subtracts, k even adds (i_k holds k - 1)
            o_sum <= i_k[0] ? (r_sum + {2'b00, w_q}) : (r_sum - {2'b00, w_q});
        end
    end
endmodule

@@ rtl/vhc_square_cell.sv @@
// one rounded q.31 squaring
module vhc_square_cell import vhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_v,
    output logic [31:0] o_v
);
    logic [63:0] w_sq;

    assign w_sq = i_v * i_v + 64'd1073741824;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v <= w_sq[62:31];
        end
    end
endmodule

@@ rtl/vhc_mode_term.sv @@
// einstein term for one vibrational mode, fully pipelined
module vhc_mode_term import vhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [19:0] i_theta,
    input  logic [19:0] i_temp,
    output logic [16:0] o_term
);
    // x = theta / T in q.16
    logic [31:0] w_rem1 [C_DIV1_BITS+1];
    logic [51:0] w_dq1  [C_DIV1_BITS+1];
    logic [31:0] w_dvs1 [C_DIV1_BITS+1];

    assign w_rem1[0] = '0;
    assign w_dq1[0]  = {i_theta, 32'd0};
    assign w_dvs1[0] = {12'd0, i_temp};

    for (genvar g = 0; g < C_DIV1_BITS; g++) begin : g_div1
        vhc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem1[g]),
            .i_dq  (w_dq1[g]),
            .i_dvs (w_dvs1[g]),
            .o_rem (w_rem1[g+1]),
            .o_dq  (w_dq1[g+1]),
            .o_dvs (w_dvs1[g+1])
        );
    end

    logic [35:0] w_xq;
    t_stage_a    r_a [C_A_LEN];

    assign w_xq = w_dq1[C_DIV1_BITS][35:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0].xq    <= w_xq[20:0];
            r_a[0].big   <= (w_xq >= C_XQ_CUTOFF);
            r_a[0].low_x <= (w_xq < C_XQ_ONE);
            for (int j = 1; j < C_A_LEN; j++) begin
                r_a[j] <= r_a[j-1];
            end
        end
    end

    // exp(-x/32) by series
    logic [31:0] w_t   [C_TAYLOR_TERMS+1];
    logic [30:0] w_y   [C_TAYLOR_TERMS+1];
    logic [32:0] w_sum [C_TAYLOR_TERMS+1];

    assign w_t[0]   = 32'h8000_0000;
    assign w_y[0]   = {r_a[0].xq, 10'd0};
    assign w_sum[0] = 33'h0_8000_0000;

    for (genvar g = 0; g < C_TAYLOR_TERMS; g++) begin : g_taylor
        vhc_taylor_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_k   (4'(g)),
            .i_t   (w_t[g]),
            .i_y   (w_y[g]),
            .i_sum (w_sum[g]),
            .o_t   (w_t[g+1]),
            .o_y   (w_y[g+1]),
            .o_sum (w_sum[g+1])
        );
    end

    // raise to the 32nd power
    logic [31:0] w_sq [C_SQUARINGS+1];

    assign w_sq[0] = w_sum[C_TAYLOR_TERMS][31:0];

    for (genvar g = 0; g < C_SQUARINGS; g++) begin : g_square
        vhc_square_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (w_sq[g]),
            .o_v   (w_sq[g+1])
        );
    end

    // denominator 1 - e^-x
    logic [31:0] r_dd;
    logic [20:0] r_dxq;
    t_stage_b    r_dinfo;
    t_stage_b    r_b [C_DIV2_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd          <= 32'h8000_0000 - w_sq[C_SQUARINGS];
            r_dxq         <= r_a[C_A_LEN-1].xq;
            r_dinfo.e     <= w_sq[C_SQUARINGS];
            r_dinfo.dzero <= (w_sq[C_SQUARINGS] == 32'h8000_0000);
            r_dinfo.big   <= r_a[C_A_LEN-1].big;
            r_dinfo.low_x <= r_a[C_A_LEN-1].low_x;
            r_b[0]        <= r_dinfo;
            for (int j = 1; j < C_DIV2_BITS; j++) begin
                r_b[j] <= r_b[j-1];
            end
        end
    end

    // r = x / (1 - e^-x) in q.16
    logic [31:0] w_rem2 [C_DIV2_BITS+1];
    logic [51:0] w_dq2  [C_DIV2_BITS+1];
    logic [31:0] w_dvs2 [C_DIV2_BITS+1];

    assign w_rem2[0] = '0;
    assign w_dq2[0]  = {r_dxq, 31'd0};
    assign w_dvs2[0] = r_dd;

    for (genvar g = 0; g < C_DIV2_BITS; g++) begin : g_div2
        vhc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem2[g]),
            .i_dq  (w_dq2[g]),
            .i_dvs (w_dvs2[g]),
            .o_rem (w_rem2[g+1]),
            .o_dq  (w_dq2[g+1]),
            .o_dvs (w_dvs2[g+1])
        );
    end

    // r * r * e, rounded to q.16
    logic [23:0] w_r;
    logic [47:0] r_rr;
    t_stage_b    r_m1;
    logic [53:0] r_pl;
    logic [57:0] r_ph;
    t_stage_b    r_m2;
    logic [63:0] w_prod;
    logic [16:0] r_mid;
    t_stage_b    r_m3;

    assign w_r    = w_dq2[C_DIV2_BITS][23:0];
    assign w_prod = {r_ph[41:0], 22'd0} + {10'd0, r_pl} + 64'h0000_4000_0000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr  <= w_r * w_r;
            r_m1  <= r_b[C_DIV2_BITS-1];
            r_pl  <= r_rr[21:0] * r_m1.e;
            r_ph  <= r_rr[47:22] * r_m1.e;
            r_m2  <= r_m1;
            r_mid <= w_prod[63:47];
            r_m3  <= r_m2;
        end
    end

    // small x series, runs beside the exp chain
    logic [31:0] r_s1;
    logic [31:0] r_s2_s, r_s2_p2;
    logic [31:0] r_s3_s, r_s3_p2, r_s3_p3;
    logic [31:0] r_s4_s, r_s4_p2, r_s4_p3, r_s4_p4;
    logic [31:0] r_qa, r_qb, r_qc, r_qd;
    logic [16:0] r_sres6;
    logic [16:0] r_sres [C_SRES_LEN];
    logic [63:0] w_p2, w_p3, w_p4;
    logic [64:0] w_ma, w_mb, w_mc, w_md;
    logic [33:0] w_f;

    assign w_p2 = r_s1 * r_s1;
    assign w_p3 = r_s2_p2 * r_s2_s;
    assign w_p4 = r_s3_p3 * r_s3_s;
    assign w_ma = r_s4_s  * C_RECIP_12;
    assign w_mb = r_s4_p2 * C_RECIP_240;
    assign w_mc = r_s4_p3 * C_RECIP_6048;
    assign w_md = r_s4_p4 * C_RECIP_172800;
    assign w_f  = 34'h1_0000_0000 - {2'b00, r_qa} + {2'b00, r_qb} - {2'b00, r_qc}
                + {2'b00, r_qd} + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1    <= r_a[0].xq[15:0] * r_a[0].xq[15:0];
            r_s2_s  <= r_s1;
            r_s2_p2 <= w_p2[63:32];
            r_s3_s  <= r_s2_s;
            r_s3_p2 <= r_s2_p2;
            r_s3_p3 <= w_p3[63:32];
            r_s4_s  <= r_s3_s;
            r_s4_p2 <= r_s3_p2;
            r_s4_p3 <= r_s3_p3;
            r_s4_p4 <= w_p4[63:32];
            r_qa    <= 32'(w_ma >> 36);
            r_qb    <= 32'(w_mb >> 40);
            r_qc    <= 32'(w_mc >> 45);
            r_qd    <= 32'(w_md >> 50);
            r_sres6 <= w_f[32:16];
            r_sres[0] <= r_sres6;
            for (int j = 1; j < C_SRES_LEN; j++) begin
                r_sres[j] <= r_sres[j-1];
            end
        end
    end

    // pick the term for this range of x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_m3.big) begin
                o_term <= '0;
            end else if (r_m3.low_x) begin
                o_term <= r_sres[C_SRES_LEN-1];
            end else if (r_m3.dzero) begin
                o_term <= '0;
            end else begin
                o_term <= r_mid;
            end
        end
    end
endmodule

@@ rtl/vibrational_heat_capacity_unit.sv @@
// top level: cp/r of one gas species from temperature, einstein vibrational modes
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_temperature
// result    out        o_valid / i_stall         o_cp_over_r, o_zero_temp_error
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction per cycle while the output buffer has room; the pipeline depth is set by the
// chain of division cells (36 + 52 steps) and the 16-term exp series in each mode cell
// reset is synchronous, active low; it clears valid bits, the output buffer and the
// configuration registers (half-count 5, no modes, all thetas zero)
// a two-entry output buffer parts the sides: the pipeline keeps moving while one
// result waits and freezes, with o_stall high, only once both entries are full
module vibrational_heat_capacity_unit import vhc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_cp_over_r,
    output logic        o_zero_temp_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    // configuration registers
    logic [2:0]  r_halves;
    logic [2:0]  r_mode_count;
    logic [19:0] r_theta [C_THETA_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halves     <= C_HALVES_RST;
            r_mode_count <= '0;
            for (int j = 0; j < C_THETA_REGS; j++) begin
                r_theta[j] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                C_REG_HALVES: r_halves     <= i_cfg_data[2:0];
                C_REG_MODES:  r_mode_count <= i_cfg_data[2:0];
                C_REG_THETA0: r_theta[0]   <= i_cfg_data;
                C_REG_THETA1: r_theta[1]   <= i_cfg_data;
                C_REG_THETA2: r_theta[2]   <= i_cfg_data;
                C_REG_THETA3: r_theta[3]   <= i_cfg_data;
                C_REG_THETA4: r_theta[4]   <= i_cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // pipeline advance: frozen only while the output buffer is full
    logic [1:0] r_cnt;
    logic       w_en;
    logic       w_accept;

    assign w_en     = (r_cnt != 2'd2);
    assign o_stall  = ~w_en;
    assign w_accept = i_valid & w_en;

    // row of mode cells, one per theta register
    logic [16:0] w_term [C_NUM_CELLS];

    for (genvar g = 0; g < C_NUM_CELLS; g++) begin : g_mode
        vhc_mode_term u_term (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_theta (r_theta[g]),
            .i_temp  (i_temperature),
            .o_term  (w_term[g])
        );
    end

    // valid and zero-temperature flags ride alongside the cells
    logic r_vld  [C_TERM_LAT];
    logic r_zero [C_TERM_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < C_TERM_LAT; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_accept;
            for (int j = 1; j < C_TERM_LAT; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero[0] <= (i_temperature == '0);
            for (int j = 1; j < C_TERM_LAT; j++) begin
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    // sum of the base and the active modes
    logic [24:0] w_sum;
    logic [24:0] r_sum;
    logic        r_sum_v;
    logic        r_sum_zero;

    always_comb begin
        w_sum = {19'd0, r_halves, 3'd0} << 12;
        w_sum = w_sum + C_ONE_Q16;
        for (int j = 0; j < C_NUM_CELLS; j++) begin
            if (r_mode_count > 3'(j)) begin
                w_sum = w_sum + {8'd0, w_term[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_v <= 1'b0;
        end else if (w_en) begin
            r_sum_v <= r_vld[C_TERM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum      <= w_sum;
            r_sum_zero <= r_zero[C_TERM_LAT-1];
        end
    end

    // saturation and the zero-temperature override
    logic [23:0] w_push_cp;
    logic        w_push;
    logic        w_pop;

    always_comb begin
        if (r_sum_zero) begin
            w_push_cp = '0;
        end else if (r_sum > {1'b0, C_CP_MAX}) begin
            w_push_cp = C_CP_MAX;
        end else begin
            w_push_cp = r_sum[23:0];
        end
    end

    assign w_push = w_en & r_sum_v;
    assign w_pop  = o_valid & ~i_stall;

    // two-entry output buffer, head drives the ports
    logic [23:0] r_buf1_cp;
    logic        r_buf1_err;

    assign o_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                o_cp_over_r       <= r_buf1_cp;
                o_zero_temp_error <= r_buf1_err;
            end else if (w_push) begin
                o_cp_over_r       <= w_push_cp;
                o_zero_temp_error <= r_sum_zero;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                o_cp_over_r       <= w_push_cp;
                o_zero_temp_error <= r_sum_zero;
            end else begin
                r_buf1_cp  <= w_push_cp;
                r_buf1_err <= r_sum_zero;
            end
        end
    end
endmodule

@@ dv/tb.sv @@
// testbench for the vibrational heat capacity unit: directed and random temperatures checked against a predictor
`timescale 1ns / 100ps

module tb;
    import vhc_pkg::*;

    // register index outside the map, writes to it are dropped
    localparam logic [2:0] C_REG_UNUSED = 3'd7;

    localparam logic [19:0] C_DIR_TEMPS [16] = '{
        20'd0, 20'd1, 20'd2, 20'd16, 20'd1000, 20'd2400, 20'd4800, 20'd9600,
        20'd16000, 20'd24000, 20'd48000, 20'd96000, 20'h80000, 20'hFFFFF,
        20'h55555, 20'hAAAAA
    };

    localparam logic [2:0] C_PHASE_HALVES [8] = '{
        3'd3, 3'd7, 3'd0, 3'd4, 3'd5, 3'd6, 3'd1, 3'd2
    };

    typedef struct {
        logic [23:0] cp;
        logic        zero_err;
    } t_heat_result;

    // scoreboard: holds a copy of the species registers, predicts cp/r for every
    // accepted temperature and matches results in order
    class heat_capacity_board;
        logic [2:0]  halves;
        logic [2:0]  modes;
        logic [19:0] theta [C_THETA_REGS];
        t_heat_result pending [$];
        int errors;
        int results_seen;

        function new();
            halves = C_HALVES_RST;
            modes  = '0;
            foreach (theta[i]) theta[i] = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] data);
            case (idx)
                C_REG_HALVES: halves = data[2:0];
                C_REG_MODES:  modes  = data[2:0];
                C_REG_THETA0, C_REG_THETA1, C_REG_THETA2, C_REG_THETA3, C_REG_THETA4:
                    theta[idx - C_REG_THETA0] = data;
                default: ;
            endcase
        endfunction

        // series form for x below one, s = x^2 in q.32
        function longint unsigned series_term(longint unsigned xq);
            longint unsigned s, s2, s3, s4, f;
            s  = xq * xq;
            s2 = (s * s) >> 32;
            s3 = (s2 * s) >> 32;
            s4 = (s3 * s) >> 32;
            f  = (64'd1 << 32) - s / 12 + s2 / 240 - s3 / 6048 + s4 / 172800;
            return (f + (64'd1 << 15)) >> 16;
        endfunction

        // e^-x in q.31: taylor series at x/32, then squared five times
        function longint unsigned decay_q31(longint unsigned xq);
            longint unsigned y, acc, t;
            y = xq << 10;
            acc = 64'd1 << 31;
            t = 64'd1 << 31;
            for (int k = 1; k <= 16; k++) begin
                t = ((t * y) >> 31) / k;
                if (k % 2 == 1) acc = acc - t;
                else acc = acc + t;
            end
            for (int i = 0; i < 5; i++)
                acc = (acc * acc + (64'd1 << 30)) >> 31;
            return acc;
        endfunction

        function longint unsigned mode_term(logic [19:0] th, logic [19:0] temp);
            longint unsigned xq, e, d, r;
            xq = (longint'(th) << 16) / temp;
            if (xq < 65536) return series_term(xq);
            if (xq >= (64'd20 << 16)) return 0;
            e = decay_q31(xq);
            d = (64'd1 << 31) - e;
            if (d == 0) return 0;
            r = (xq << 31) / d;
            return ((r * r) * e + (64'd1 << 46)) >> 47;
        endfunction

        function void note_temperature(logic [19:0] temp);
            t_heat_result res;
            longint unsigned acc;
            int n;
            if (temp == 0) begin
                res.cp = '0;
                res.zero_err = 1'b1;
            end else begin
                n = modes;
                if (n > C_NUM_CELLS) n = C_NUM_CELLS;
                acc = (longint'(halves) << 15) + 65536;
                for (int i = 0; i < n; i++) acc += mode_term(theta[i], temp);
                res.cp = (acc > C_CP_MAX) ? C_CP_MAX : acc[23:0];
                res.zero_err = 1'b0;
            end
            pending.insert(pending.size(), res);
        endfunction

        function void check_result(logic [23:0] cp, logic zero_err);
            t_heat_result exp_res;
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: result cp=%h err=%b with nothing expected", $realtime, cp, zero_err);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (cp !== exp_res.cp) begin
                $display("%0t: cp_over_r expected %h actual %h", $realtime, exp_res.cp, cp);
                errors++;
            end
            if (zero_err !== exp_res.zero_err) begin
                $display("%0t: zero_temp_error expected %b actual %b",
                         $realtime, exp_res.zero_err, zero_err);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [19:0] i_temperature;
    logic        o_valid;
    logic        i_stall;
    logic [23:0] o_cp_over_r;
    logic        o_zero_temp_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    heat_capacity_board board;
    bit hold_results;      // asks the result side for one long hold-off
    int temps_sent;

    vibrational_heat_capacity_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // both channels are sampled at the edge, before the nonblocking updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note_temperature(i_temperature);
            if (o_valid && !i_stall) board.check_result(o_cp_over_r, o_zero_temp_error);
        end
    end

    // result side: random stall bursts, quiet stretches, and the long hold on request
    initial begin
        int len;
        int pick;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_results) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_results = 0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else if (pick < 85) begin
                    i_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else if (pick < 95) begin
                    i_stall <= 1'b0;
                    len = $urandom_range(50, 150);
                end else begin
                    i_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // one register write; valid stays up so back-to-back writes need no toggling
    task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic cfg_idle();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one temperature, hold it until accepted, then maybe leave a gap
    task automatic send_temperature(logic [19:0] temp, bit gaps);
        int pick;
        int gap;
        i_valid <= 1'b1;
        i_temperature <= temp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        temps_sent++;
        gap = 0;
        if (gaps) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) gap = 0;
            else if (pick < 92) gap = $urandom_range(1, 3);
            else gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // temperature near a chosen x region of one of the theta registers
    function automatic logic [19:0] pick_temperature();
        logic [19:0] th;
        longint unsigned t;
        int sel;
        th = board.theta[$urandom_range(0, C_THETA_REGS - 1)];
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: t = 64'($urandom_range(0, 20'hFFFFF));
            2: t = (sel == 2 && $urandom_range(0, 3) == 0) ? 64'd0
                                                           : 64'($urandom_range(1, 64));
            3, 4: t = longint'(th) / $urandom_range(1, 20) + $urandom_range(0, 3);
            5: t = (longint'(th) * 16) / $urandom_range(300, 400);
            6, 7: t = longint'(th) * $urandom_range(1, 6) + $urandom_range(0, 255);
            default: t = (longint'(th) << 4) / $urandom_range(1, 400);
        endcase
        if (t > 20'hFFFFF) t = 20'hFFFFF;
        return t[19:0];
    endfunction

    initial begin
        logic [19:0] th;
        int phase;
        board = new();
        temps_sent = 0;
        hold_results = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_temperature <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: no modes, zero temperature flagged
        send_temperature(20'd0, 0);
        send_temperature(20'd1, 0);
        send_temperature(20'hFFFFF, 0);
        wait_drained();

        // directed: zero theta, unused and oversized mode counts, all x regions
        cfg_write(C_REG_HALVES, 20'd6);
        cfg_write(C_REG_MODES, 20'd7);
        cfg_write(C_REG_THETA0, 20'd0);
        cfg_write(C_REG_THETA1, 20'd48000);
        cfg_write(C_REG_THETA2, 20'hFFFFF);
        cfg_write(C_REG_THETA3, 20'd1);
        cfg_write(C_REG_THETA4, 20'd16000);
        cfg_write(C_REG_UNUSED, 20'hFFFFF);     // unknown index, must be ignored
        cfg_idle();
        for (int i = 0; i < 16; i++)
            send_temperature(C_DIR_TEMPS[i], 0);
        wait_drained();

        // random phases, each with its own species setup
        for (phase = 0; phase < 8; phase++) begin
            cfg_write(C_REG_HALVES, 20'(C_PHASE_HALVES[phase]));
            cfg_write(C_REG_MODES, 20'((phase + 3) % 8));
            for (int m = 0; m < C_THETA_REGS; m++) begin
                case (phase)
                    0: th = 20'hFFFFF;
                    1: th = 20'd0;
                    default: th = ($urandom_range(0, 1) != 0)
                                  ? 20'($urandom_range(1, 20'hFFFFF))
                                  : 20'($urandom_range(1, 40000));
                endcase
                cfg_write(3'(C_REG_THETA0 + m), th);
            end
            cfg_write(C_REG_UNUSED, 20'($urandom_range(0, 20'hFFFFF)));
            cfg_idle();

            for (int n = 0; n < 250; n++) begin
                // fill the pipe against a stalled receiver once
                if (phase == 3 && n == 20) hold_results = 1;
                // sender waits for every outstanding result once
                if (phase == 5 && n == 125) wait_drained();
                send_temperature(pick_temperature(), 1);
            end
            wait_drained();
        end

        repeat (150) @(posedge i_clk);
        $display("covered %0d temperatures and %0d results over 8 species setups",
                 temps_sent, board.results_seen);
        $display("zero and extreme temperatures, series, exponential and underflow terms");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ vibrational_heat_capacity_unit.f @@
rtl/vhc_pkg.sv
rtl/vhc_div_cell.sv
rtl/vhc_taylor_cell.sv
rtl/vhc_square_cell.sv
rtl/vhc_mode_term.sv
rtl/vibrational_heat_capacity_unit.sv
dv/tb.sv
